[rtl/core/bavg_pkg.sv]
// Shared types and constants for the block average downsampler.
package bavg_pkg;

  localparam int unsigned CFG_W          = 13;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned SUM_W          = 24;
  localparam int unsigned AREA_W         = 17;
  localparam int unsigned LED_W          = 12;
  localparam int unsigned QDEPTH         = 4;
  localparam int unsigned QCNT_W         = 3;
  localparam int unsigned MAX_SOURCE_WIDTH = 4096;
  localparam int unsigned MAX_BLOCK_SIDE   = 256;

  localparam logic [12:0] SW_RESET   = 13'd64;
  localparam logic [6:0]  COLS_RESET = 7'd16;
  localparam logic [6:0]  ROWS_RESET = 7'd16;
  localparam logic [8:0]  BW_RESET   = 9'd4;
  localparam logic [8:0]  BH_RESET   = 9'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH = 3'd0,
    CFG_OUT_COLUMNS  = 3'd1,
    CFG_OUT_ROWS     = 3'd2,
    CFG_BLOCK_WIDTH  = 3'd3,
    CFG_BLOCK_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0]       red_avg;
    logic [7:0]       green_avg;
    logic [7:0]       blue_avg;
    logic [LED_W-1:0] led_index;
    logic             frame_last;
  } result_t;

  typedef struct packed {
    logic [12:0] sw;
    logic [6:0]  cols;
    logic [6:0]  rows;
    logic [8:0]  bw;
    logic [8:0]  bh;
  } geom_t;

  typedef struct packed {
    logic [SUM_W-1:0] red;
    logic [SUM_W-1:0] green;
    logic [SUM_W-1:0] blue;
  } sum_t;

  typedef struct packed {
    sum_t             sums;
    logic [LED_W-1:0] led;
    logic             last;
  } blk_t;

endpackage

[rtl/core/bavg_div.sv]
// Restoring divider, one quotient bit per cycle.
module bavg_div #(
  parameter int unsigned NUM_W = 24,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] rem_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic             busy_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_d;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(NUM_W);
      quo_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= rem_d;
      cnt_q <= cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

[rtl/core/bavg_fifo.sv]
// Block queue between the accumulating front end and the averaging back end.
module bavg_fifo (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  bavg_pkg::blk_t                      data_i,
  input  logic                                pop_i,
  output bavg_pkg::blk_t                      data_o,
  output logic                                empty_o,
  output logic [bavg_pkg::QCNT_W-1:0]         count_o
);

  localparam int unsigned PTR_W = $clog2(bavg_pkg::QDEPTH);

  bavg_pkg::blk_t                 entries_q [bavg_pkg::QDEPTH];
  logic [PTR_W-1:0]               wptr_q;
  logic [PTR_W-1:0]               rptr_q;
  logic [bavg_pkg::QCNT_W-1:0]    count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        entries_q[wptr_q] <= data_i;
        wptr_q            <= wptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + bavg_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - bavg_pkg::QCNT_W'(1);
      end
    end
  end

  assign data_o  = entries_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

[rtl/core/bavg_front.sv]
// Front end: pixel position tracking, per-column accumulation and block detection.
module bavg_front #(
  parameter int unsigned MAX_OUT_COLUMNS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bavg_pkg::geom_t               geom_i,
  input  logic                          cfg_we_i,
  input  logic                          push_i,
  input  bavg_pkg::pixel_t              pixel_i,
  output logic                          full_o,
  input  logic [bavg_pkg::QCNT_W-1:0]   fifo_count_i,
  output logic                          fifo_push_o,
  output bavg_pkg::blk_t                fifo_data_o
);

  localparam int unsigned KW = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;

  typedef enum logic [1:0] {
    RC_START,
    RC_WAIT,
    RC_READY
  } rc_state_e;

  rc_state_e   state_q;
  logic [11:0] col_q;
  logic [7:0]  line_q;
  logic [6:0]  band_q;
  logic [11:0] k_q;
  logic [7:0]  off_q;
  logic [12:0] fit_q;
  logic [12:0] lastk_q;

  logic             p_vld_q;
  logic [11:0]      p_k_q;
  logic             p_first_q;
  logic             p_emit_q;
  logic             p_last_q;
  logic [6:0]       p_band_q;
  logic [7:0]       p_red_q;
  logic [7:0]       p_green_q;
  logic [7:0]       p_blue_q;

  bavg_pkg::sum_t          sums_q [MAX_OUT_COLUMNS];
  logic [MAX_OUT_COLUMNS-1:0] vld_q;
  bavg_pkg::sum_t          rd_q;
  bavg_pkg::sum_t          wr_sum_q;
  logic [KW-1:0]           wr_idx_q;
  logic                    wr_vld_q;

  logic        div_start;
  logic        col_busy;
  logic        sw_busy;
  logic [12:0] col_quo;
  logic [8:0]  col_rem;
  logic [12:0] sw_quo;
  logic [12:0] cols13;
  logic [12:0] lastk_d;

  logic        fs;
  logic        accept;
  logic [11:0] col_e;
  logic [7:0]  line_e;
  logic [6:0]  band_e;
  logic [11:0] k_e;
  logic [7:0]  off_e;
  logic        in_range;
  logic        hit;
  logic        off_end;
  logic        line_end;
  logic        emit;
  logic        first;
  logic        last;
  logic [11:0] col_n;
  logic        col_wrap;
  logic [7:0]  line_n;
  logic        line_wrap;
  logic [KW-1:0] k_idx_e;
  logic [KW-1:0] p_idx;
  logic [3:0]  q_level;

  bavg_pkg::sum_t base_sum;
  bavg_pkg::sum_t sum_d;
  logic [13:0]    led_prod;

  assign div_start = (state_q == RC_START);

  bavg_div #(.NUM_W(13), .DEN_W(9)) u_col_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({1'b0, col_q}),
    .den_i   (geom_i.bw),
    .busy_o  (col_busy),
    .quo_o   (col_quo),
    .rem_o   (col_rem)
  );

  bavg_div #(.NUM_W(13), .DEN_W(9)) u_sw_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (geom_i.sw),
    .den_i   (geom_i.bw),
    .busy_o  (sw_busy),
    .quo_o   (sw_quo),
    .rem_o   ()
  );

  assign cols13  = 13'(geom_i.cols);
  assign lastk_d = ((cols13 < sw_quo) ? cols13 : sw_quo) - 13'd1;

  assign q_level = 4'(fifo_count_i) + 4'(p_vld_q && p_emit_q);
  assign full_o  = (state_q != RC_READY) || (q_level >= 4'(bavg_pkg::QDEPTH));
  assign accept  = push_i && !full_o;

  assign fs     = pixel_i.frame_start;
  assign col_e  = fs ? '0 : col_q;
  assign line_e = fs ? '0 : line_q;
  assign band_e = fs ? '0 : band_q;
  assign k_e    = fs ? '0 : k_q;
  assign off_e  = fs ? '0 : off_q;

  assign in_range = ({1'b0, col_e} < geom_i.sw) && ({1'b0, line_e} < geom_i.bh)
                    && (band_e < geom_i.rows);
  assign hit      = in_range && (k_e < 12'(geom_i.cols)) && ({1'b0, k_e} < fit_q);
  assign off_end  = ({1'b0, off_e} == geom_i.bw - 9'd1);
  assign line_end = ({1'b0, line_e} == geom_i.bh - 9'd1);
  assign emit     = hit && off_end && line_end;
  assign first    = (line_e == '0) && (off_e == '0);
  assign last     = (band_e == geom_i.rows - 7'd1) && ({1'b0, k_e} == lastk_q);

  assign col_n     = col_e + 12'd1;
  assign col_wrap  = ({1'b0, col_n} >= geom_i.sw) || (col_n == '0);
  assign line_n    = line_e + 8'd1;
  assign line_wrap = ({1'b0, line_n} >= geom_i.bh) || (line_n == '0);

  assign k_idx_e = k_e[KW-1:0];
  assign p_idx   = p_k_q[KW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= RC_START;
      col_q    <= '0;
      line_q   <= '0;
      band_q   <= '0;
      k_q      <= '0;
      off_q    <= '0;
      fit_q    <= '0;
      lastk_q  <= '0;
      p_vld_q  <= 1'b0;
      wr_vld_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      p_vld_q  <= accept && hit;
      wr_vld_q <= p_vld_q;
      if (p_vld_q) begin
        vld_q[p_idx] <= 1'b1;
        wr_idx_q     <= p_idx;
        wr_sum_q     <= sum_d;
      end
      if (accept && hit) begin
        p_k_q     <= k_e;
        p_first_q <= first;
        p_emit_q  <= emit;
        p_last_q  <= last;
        p_band_q  <= band_e;
        p_red_q   <= pixel_i.red_in;
        p_green_q <= pixel_i.green_in;
        p_blue_q  <= pixel_i.blue_in;
      end
      if (cfg_we_i) begin
        state_q <= RC_START;
      end else begin
        unique case (state_q)
          RC_START: begin
            state_q <= RC_WAIT;
          end
          RC_WAIT: begin
            if (!col_busy && !sw_busy) begin
              k_q     <= col_quo[11:0];
              off_q   <= col_rem[7:0];
              fit_q   <= sw_quo;
              lastk_q <= lastk_d;
              state_q <= RC_READY;
            end
          end
          RC_READY: begin
            if (accept) begin
              if (col_wrap) begin
                col_q <= '0;
                k_q   <= '0;
                off_q <= '0;
                if (line_wrap) begin
                  line_q <= '0;
                  band_q <= (band_e < geom_i.rows) ? band_e + 7'd1 : band_e;
                end else begin
                  line_q <= line_n;
                  band_q <= band_e;
                end
              end else begin
                col_q  <= col_n;
                line_q <= line_e;
                band_q <= band_e;
                if (off_end) begin
                  off_q <= '0;
                  k_q   <= k_e + 12'd1;
                end else begin
                  off_q <= off_e + 8'd1;
                  k_q   <= k_e;
                end
              end
            end
          end
          default: begin
            state_q <= RC_START;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && hit) begin
      rd_q <= sums_q[k_idx_e];
    end
    if (p_vld_q) begin
      sums_q[p_idx] <= sum_d;
    end
  end

  always_comb begin
    if (p_first_q) begin
      base_sum = '0;
    end else if (wr_vld_q && (wr_idx_q == p_idx)) begin
      base_sum = wr_sum_q;
    end else if (vld_q[p_idx]) begin
      base_sum = rd_q;
    end else begin
      base_sum = '0;
    end
    sum_d.red   = base_sum.red   + bavg_pkg::SUM_W'(p_red_q);
    sum_d.green = base_sum.green + bavg_pkg::SUM_W'(p_green_q);
    sum_d.blue  = base_sum.blue  + bavg_pkg::SUM_W'(p_blue_q);
  end

  assign led_prod         = 14'(p_band_q) * 14'(geom_i.cols);
  assign fifo_push_o      = p_vld_q && p_emit_q;
  assign fifo_data_o.sums = sum_d;
  assign fifo_data_o.led  = led_prod[11:0] + p_k_q;
  assign fifo_data_o.last = p_last_q;

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push_o |-> (fifo_count_i < bavg_pkg::QCNT_W'(bavg_pkg::QDEPTH)))
    else $error("block queue pushed while full");

  a_off_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RC_READY) |-> ({1'b0, off_q} < geom_i.bw))
    else $error("block offset outside block width");

  a_fwd_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_vld_q |-> vld_q[wr_idx_q])
    else $error("written column not marked valid");
`endif

endmodule

[rtl/core/bavg_back.sv]
// Back end: divides block sums by block area and holds the result beat.
module bavg_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bavg_pkg::geom_t   geom_i,
  input  bavg_pkg::blk_t    blk_i,
  input  logic              fifo_empty_i,
  output logic              fifo_pop_o,
  output bavg_pkg::result_t result_o,
  output logic              empty_o,
  input  logic              pop_i
);

  typedef enum logic {
    BK_IDLE,
    BK_DIV
  } bk_state_e;

  bk_state_e                       state_q;
  logic                            res_vld_q;
  bavg_pkg::result_t               res_q;
  logic [bavg_pkg::LED_W-1:0]      led_q;
  logic                            last_q;
  logic [bavg_pkg::AREA_W-1:0]     area_q;
  logic [17:0]                     area_prod;

  logic                            r_busy;
  logic                            g_busy;
  logic                            b_busy;
  logic [bavg_pkg::SUM_W-1:0]      r_quo;
  logic [bavg_pkg::SUM_W-1:0]      g_quo;
  logic [bavg_pkg::SUM_W-1:0]      b_quo;
  logic                            out_pop;
  logic                            load;

  assign area_prod  = 18'(geom_i.bw) * 18'(geom_i.bh);
  assign fifo_pop_o = (state_q == BK_IDLE) && !fifo_empty_i;
  assign out_pop    = pop_i && res_vld_q;
  assign load       = (state_q == BK_DIV) && !(r_busy || g_busy || b_busy)
                      && (!res_vld_q || out_pop);

  bavg_div #(.NUM_W(bavg_pkg::SUM_W), .DEN_W(bavg_pkg::AREA_W)) u_red_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fifo_pop_o),
    .num_i   (blk_i.sums.red),
    .den_i   (area_q),
    .busy_o  (r_busy),
    .quo_o   (r_quo),
    .rem_o   ()
  );

  bavg_div #(.NUM_W(bavg_pkg::SUM_W), .DEN_W(bavg_pkg::AREA_W)) u_green_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fifo_pop_o),
    .num_i   (blk_i.sums.green),
    .den_i   (area_q),
    .busy_o  (g_busy),
    .quo_o   (g_quo),
    .rem_o   ()
  );

  bavg_div #(.NUM_W(bavg_pkg::SUM_W), .DEN_W(bavg_pkg::AREA_W)) u_blue_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fifo_pop_o),
    .num_i   (blk_i.sums.blue),
    .den_i   (area_q),
    .busy_o  (b_busy),
    .quo_o   (b_quo),
    .rem_o   ()
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      area_q <= area_prod[bavg_pkg::AREA_W-1:0];
      if (load) begin
        res_vld_q        <= 1'b1;
        res_q.red_avg    <= r_quo[7:0];
        res_q.green_avg  <= g_quo[7:0];
        res_q.blue_avg   <= b_quo[7:0];
        res_q.led_index  <= led_q;
        res_q.frame_last <= last_q;
      end else if (out_pop) begin
        res_vld_q <= 1'b0;
      end
      unique case (state_q)
        BK_IDLE: begin
          if (fifo_pop_o) begin
            led_q   <= blk_i.led;
            last_q  <= blk_i.last;
            state_q <= BK_DIV;
          end
        end
        BK_DIV: begin
          if (load) begin
            state_q <= BK_IDLE;
          end
        end
        default: begin
          state_q <= BK_IDLE;
        end
      endcase
    end
  end

  assign result_o = res_q;
  assign empty_o  = !res_vld_q;

endmodule

[rtl/core/block_average_downsampler.sv]
// Block average downsampler top level: configuration registers and block wiring.
// Accepts one source pixel per clock while full is low, in raster order, and
// sums each color over blocks of block_width by block_height pixels, one
// accumulator set per output column. Each completed block yields one result
// beat holding the truncated channel averages, its row-major LED index and a
// last-block flag, in the order the blocks complete. The back-end divider
// computes 24 quotient bits, one per cycle, for the three channels side by
// side; a four-deep block queue lets the pixel side run on while it works, so
// pixels stall when that queue fills. After reset and after every
// configuration write, full also stays high while two 13-step dividers
// recompute the block position and blocks per line.
module block_average_downsampler #(
  parameter int unsigned MAX_OUT_COLUMNS = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  bavg_pkg::pixel_t                   pixel_i,
  output logic                               empty,
  input  logic                               pop,
  output bavg_pkg::result_t                  result_o,
  input  logic                               cfg_we_i,
  input  logic [bavg_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bavg_pkg::CFG_W-1:0]         cfg_data_i
);

  logic [12:0] sw_q;
  logic [6:0]  cols_q;
  logic [6:0]  rows_q;
  logic [8:0]  bw_q;
  logic [8:0]  bh_q;

  bavg_pkg::geom_t                 geom;
  bavg_pkg::blk_t                  push_data;
  bavg_pkg::blk_t                  head_data;
  logic                            q_push;
  logic                            q_pop;
  logic                            q_empty;
  logic [bavg_pkg::QCNT_W-1:0]     q_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q   <= bavg_pkg::SW_RESET;
      cols_q <= bavg_pkg::COLS_RESET;
      rows_q <= bavg_pkg::ROWS_RESET;
      bw_q   <= bavg_pkg::BW_RESET;
      bh_q   <= bavg_pkg::BH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bavg_pkg::CFG_SOURCE_WIDTH: sw_q   <= cfg_data_i[12:0];
        bavg_pkg::CFG_OUT_COLUMNS:  cols_q <= cfg_data_i[6:0];
        bavg_pkg::CFG_OUT_ROWS:     rows_q <= cfg_data_i[6:0];
        bavg_pkg::CFG_BLOCK_WIDTH:  bw_q   <= cfg_data_i[8:0];
        bavg_pkg::CFG_BLOCK_HEIGHT: bh_q   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sw_q == '0) begin
      geom.sw = 13'd1;
    end else if (sw_q > 13'(bavg_pkg::MAX_SOURCE_WIDTH)) begin
      geom.sw = 13'(bavg_pkg::MAX_SOURCE_WIDTH);
    end else begin
      geom.sw = sw_q;
    end
    if (cols_q == '0) begin
      geom.cols = 7'd1;
    end else if (32'(cols_q) > MAX_OUT_COLUMNS) begin
      geom.cols = 7'(MAX_OUT_COLUMNS);
    end else begin
      geom.cols = cols_q;
    end
    geom.rows = (rows_q == '0) ? 7'd1 : rows_q;
    if (bw_q == '0) begin
      geom.bw = 9'd1;
    end else if (bw_q > 9'(bavg_pkg::MAX_BLOCK_SIDE)) begin
      geom.bw = 9'(bavg_pkg::MAX_BLOCK_SIDE);
    end else begin
      geom.bw = bw_q;
    end
    if (bh_q == '0) begin
      geom.bh = 9'd1;
    end else if (bh_q > 9'(bavg_pkg::MAX_BLOCK_SIDE)) begin
      geom.bh = 9'(bavg_pkg::MAX_BLOCK_SIDE);
    end else begin
      geom.bh = bh_q;
    end
  end

  bavg_front #(.MAX_OUT_COLUMNS(MAX_OUT_COLUMNS)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .cfg_we_i     (cfg_we_i),
    .push_i       (push),
    .pixel_i      (pixel_i),
    .full_o       (full),
    .fifo_count_i (q_count),
    .fifo_push_o  (q_push),
    .fifo_data_o  (push_data)
  );

  bavg_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_data),
    .pop_i   (q_pop),
    .data_o  (head_data),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  bavg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .geom_i       (geom),
    .blk_i        (head_data),
    .fifo_empty_i (q_empty),
    .fifo_pop_o   (q_pop),
    .result_o     (result_o),
    .empty_o      (empty),
    .pop_i        (pop)
  );

endmodule
